>>> sv/i2cmbs_pkg.sv
// Package with request codes, phase actions and the phase decode of the I2C bit sequencer.
package i2cmbs_pkg;

  localparam int unsigned HalfPeriodW     = 16;
  localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 16'd40;
  localparam int unsigned PhaseW          = 5;

  typedef logic [2:0] req_t;

  localparam req_t REQ_TICK      = 3'd0;
  localparam req_t REQ_START     = 3'd1;
  localparam req_t REQ_START_ADR = 3'd2;
  localparam req_t REQ_STOP      = 3'd3;
  localparam req_t REQ_WRITE     = 3'd4;
  localparam req_t REQ_WRITE_NA  = 3'd5;
  localparam req_t REQ_READ      = 3'd6;
  localparam req_t REQ_UNUSED    = 3'd7;

  typedef enum logic [3:0] {
    OP_END      = 4'd0,
    OP_SCL_HI   = 4'd1,
    OP_SCL_LO   = 4'd2,
    OP_SDA_LO   = 4'd3,
    OP_SDA_REL  = 4'd4,
    OP_LO_BIT   = 4'd5,
    OP_HI_SHIFT = 4'd6,
    OP_LO_REL   = 4'd7,
    OP_HI_ACK   = 4'd8,
    OP_HI_READ  = 4'd9,
    OP_ACK_SLOT = 4'd10
  } op_t;

  // Line levels: scl is the SCL level, sda_low is the SDA pull-down.
  typedef struct packed {
    logic scl;
    logic sda_low;
  } lines_t;

  function automatic op_t write_op(input logic [PhaseW-1:0] p, input logic with_ack);
    op_t op;
    if (p < 5'd16) begin
      op = p[0] ? OP_HI_SHIFT : OP_LO_BIT;
    end else if (p == 5'd16) begin
      op = OP_SCL_LO;
    end else if (!with_ack) begin
      op = OP_END;
    end else begin
      case (p)
        5'd17:   op = OP_SDA_REL;
        5'd18:   op = OP_HI_ACK;
        5'd19:   op = OP_SCL_LO;
        default: op = OP_END;
      endcase
    end
    return op;
  endfunction

  function automatic op_t phase_op(input req_t cmd, input logic [PhaseW-1:0] p);
    op_t op;
    op = OP_END;
    unique case (cmd)
      REQ_START: begin
        op = (p == 5'd0) ? OP_SCL_HI : ((p == 5'd1) ? OP_SDA_LO : OP_END);
      end
      REQ_START_ADR: begin
        if (p == 5'd0) op = OP_SCL_HI;
        else if (p == 5'd1) op = OP_SDA_LO;
        else op = write_op(p - 5'd2, 1'b1);
      end
      REQ_STOP: begin
        case (p)
          5'd0:    op = OP_SDA_LO;
          5'd1:    op = OP_SCL_HI;
          5'd2:    op = OP_SDA_REL;
          default: op = OP_END;
        endcase
      end
      REQ_WRITE:    op = write_op(p, 1'b1);
      REQ_WRITE_NA: op = write_op(p, 1'b0);
      REQ_READ: begin
        if (p < 5'd16) begin
          op = p[0] ? OP_HI_READ : OP_LO_REL;
        end else begin
          case (p)
            5'd16:   op = OP_LO_REL;
            5'd17:   op = OP_ACK_SLOT;
            5'd18:   op = OP_SCL_HI;
            5'd19:   op = OP_SCL_LO;
            5'd20:   op = OP_SDA_REL;
            default: op = OP_END;
          endcase
        end
      end
      default: op = OP_END;
    endcase
    return op;
  endfunction

  function automatic lines_t enter_op(input op_t op, input lines_t cur, input logic msb,
                                      input logic ack_sel);
    lines_t l;
    l = cur;
    case (op) inside
      OP_SCL_HI, OP_HI_SHIFT, OP_HI_ACK, OP_HI_READ: l.scl = 1'b1;
      OP_SCL_LO:   l.scl = 1'b0;
      OP_SDA_LO:   l.sda_low = 1'b1;
      OP_SDA_REL:  l.sda_low = 1'b0;
      OP_LO_BIT: begin
        l.scl = 1'b0;
        l.sda_low = ~msb;
      end
      OP_LO_REL: begin
        l.scl = 1'b0;
        l.sda_low = 1'b0;
      end
      OP_ACK_SLOT: l.sda_low = ack_sel;
      default: l = cur;
    endcase
    return l;
  endfunction

endpackage

>>> sv/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer: tick handling, phase sequencing and result register.
//
// Each input beat is one tick of the bus timebase and produces exactly one output beat
// carrying the SCL level, the SDA pull-down, busy, done, the last byte read, the last ACK
// seen and a flag for a command that arrived while busy. A beat is accepted every cycle
// unless a finished result is stalled at the output, so the rate is one tick per clock;
// the whole step is one pass through the phase decode between the sequencer state and
// the result register, and results appear in the cycle after their tick. Commands are taken
// only while idle; every half_period ticks (zero counts as one) the sequence advances one
// bus phase, and the first phase of a command is applied on the tick that accepts it.
module i2c_master_bit_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [i2cmbs_pkg::HalfPeriodW-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  i2cmbs_pkg::req_t               req_type,
  input  logic [7:0]                     data_byte,
  input  logic                           send_ack,
  input  logic                           sda_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           scl_level,
  output logic                           sda_drive_low,
  output logic                           busy_res,
  output logic                           done_res,
  output logic [7:0]                     read_byte,
  output logic                           ack_received,
  output logic                           rejected
);
  import i2cmbs_pkg::*;

  logic [HalfPeriodW-1:0] half_period;
  logic [PhaseW-1:0]      sequence_phase, sequence_phase_next;
  req_t                   active_command, active_command_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [HalfPeriodW-1:0] tick_divider, tick_divider_next;
  logic                   ack_choice, ack_choice_next;
  logic                   last_ack, last_ack_next;
  lines_t                 line_levels, line_levels_next;
  logic                   seq_busy, seq_busy_next;
  logic [7:0]             read_result, read_result_next;
  logic                   done, rej;

  logic                   accept;
  logic                   is_cmd;
  logic [HalfPeriodW-1:0] hp;
  logic [HalfPeriodW-1:0] td_inc;
  logic [PhaseW-1:0]      phase_inc;
  op_t                    cur_op, new_op;
  logic [7:0]             shifted;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign is_cmd   = (req_type != REQ_TICK) && (req_type != REQ_UNUSED);
  assign hp       = (half_period == '0) ? {{(HalfPeriodW-1){1'b0}}, 1'b1} : half_period;
  assign td_inc   = tick_divider + 1'b1;
  assign phase_inc = sequence_phase + 1'b1;
  assign cur_op   = phase_op(active_command, sequence_phase);
  assign new_op   = phase_op(active_command, phase_inc);

  always_comb begin
    case (cur_op)
      OP_HI_SHIFT: shifted = {shift_byte[6:0], 1'b0};
      OP_HI_READ:  shifted = {shift_byte[6:0], sda_in};
      default:     shifted = shift_byte;
    endcase
  end

  always_comb begin
    sequence_phase_next = sequence_phase;
    active_command_next = active_command;
    shift_byte_next     = shift_byte;
    tick_divider_next   = tick_divider;
    ack_choice_next     = ack_choice;
    last_ack_next       = last_ack;
    line_levels_next    = line_levels;
    seq_busy_next       = seq_busy;
    read_result_next    = read_result;
    done                = 1'b0;
    rej                 = 1'b0;
    if (seq_busy) begin
      rej = is_cmd;
      tick_divider_next = td_inc;
      if (td_inc >= hp) begin
        tick_divider_next = '0;
        shift_byte_next   = shifted;
        if (cur_op == OP_HI_ACK) begin
          last_ack_next = ~sda_in;
        end
        if (new_op == OP_END) begin
          if (active_command == REQ_READ) begin
            read_result_next = shifted;
          end
          seq_busy_next       = 1'b0;
          sequence_phase_next = '0;
          done                = 1'b1;
        end else begin
          sequence_phase_next = phase_inc;
          line_levels_next    = enter_op(new_op, line_levels, shifted[7], ack_choice);
        end
      end
    end else if (is_cmd) begin
      active_command_next = req_type;
      sequence_phase_next = '0;
      tick_divider_next   = '0;
      shift_byte_next     = (req_type == REQ_READ) ? 8'h00 : data_byte;
      ack_choice_next     = send_ack;
      seq_busy_next       = 1'b1;
      line_levels_next    = enter_op(phase_op(req_type, '0), line_levels,
                                     (req_type == REQ_READ) ? 1'b0 : data_byte[7], send_ack);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HalfPeriodReset;
    end else if (cfg_we) begin
      half_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_phase <= '0;
      active_command <= REQ_TICK;
      shift_byte     <= '0;
      tick_divider   <= '0;
      ack_choice     <= 1'b0;
      last_ack       <= 1'b0;
      line_levels    <= '{scl: 1'b1, sda_low: 1'b0};
      seq_busy       <= 1'b0;
      read_result    <= '0;
    end else if (accept) begin
      sequence_phase <= sequence_phase_next;
      active_command <= active_command_next;
      shift_byte     <= shift_byte_next;
      tick_divider   <= tick_divider_next;
      ack_choice     <= ack_choice_next;
      last_ack       <= last_ack_next;
      line_levels    <= line_levels_next;
      seq_busy       <= seq_busy_next;
      read_result    <= read_result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level     <= line_levels_next.scl;
      sda_drive_low <= line_levels_next.sda_low;
      busy_res      <= seq_busy_next;
      done_res      <= done;
      read_byte     <= read_result_next;
      ack_received  <= last_ack_next;
      rejected      <= rej;
    end
  end

endmodule

>>> tb/tb_i2c_master_bit_sequencer_unit.sv
// Self-checking testbench for the I2C master bit sequencer, with its own tick-level bus model.
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer_unit;
  import i2cmbs_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       ack;
    logic       rej;
  } bus_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [HalfPeriodW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  req_t req_type;
  logic [7:0] data_byte;
  logic send_ack;
  logic sda_in;
  logic out_valid;
  logic out_stall;
  logic scl_level;
  logic sda_drive_low;
  logic busy_res;
  logic done_res;
  logic [7:0] read_byte;
  logic ack_received;
  logic rejected;

  // Bus model state.
  logic [15:0] seq_half_period;
  int unsigned seq_phase;
  req_t seq_cmd;
  logic [7:0] seq_shift;
  logic [15:0] seq_div;
  logic seq_ack_choice;
  logic seq_last_ack;
  logic seq_scl;
  logic seq_sda_low;
  logic seq_busy;
  logic [7:0] seq_read_byte;

  bus_beat_t expected_bus_beats[$];
  int error_count;
  bit idle_enable;
  int unsigned hold_request;

  i2c_master_bit_sequencer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .send_ack     (send_ack),
    .sda_in       (sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_level    (scl_level),
    .sda_drive_low(sda_drive_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .read_byte    (read_byte),
    .ack_received (ack_received),
    .rejected     (rejected)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic op_t phase_action(input req_t cmd, input int unsigned p);
    int unsigned q;
    q = p;
    case (cmd)
      REQ_START, REQ_START_ADR: begin
        if (p == 0) return OP_SCL_HI;
        if (p == 1) return OP_SDA_LO;
        if (cmd == REQ_START) return OP_END;
        q = p - 2;
      end
      REQ_STOP: begin
        if (p == 0) return OP_SDA_LO;
        if (p == 1) return OP_SCL_HI;
        if (p == 2) return OP_SDA_REL;
        return OP_END;
      end
      REQ_READ: begin
        if (p < 16) return (p % 2 == 1) ? OP_HI_READ : OP_LO_REL;
        if (p == 16) return OP_LO_REL;
        if (p == 17) return OP_ACK_SLOT;
        if (p == 18) return OP_SCL_HI;
        if (p == 19) return OP_SCL_LO;
        if (p == 20) return OP_SDA_REL;
        return OP_END;
      end
      REQ_WRITE, REQ_WRITE_NA: begin
      end
      default: return OP_END;
    endcase
    // Byte transmission, shared by both writes and the address after a start.
    if (q < 16) return (q % 2 == 1) ? OP_HI_SHIFT : OP_LO_BIT;
    if (q == 16) return OP_SCL_LO;
    if (cmd == REQ_WRITE_NA || q > 19) return OP_END;
    if (q == 17) return OP_SDA_REL;
    if (q == 18) return OP_HI_ACK;
    return OP_SCL_LO;
  endfunction

  function automatic void apply_phase(input op_t op);
    case (op)
      OP_SCL_HI, OP_HI_SHIFT, OP_HI_ACK, OP_HI_READ: seq_scl = 1'b1;
      OP_SCL_LO:   seq_scl = 1'b0;
      OP_SDA_LO:   seq_sda_low = 1'b1;
      OP_SDA_REL:  seq_sda_low = 1'b0;
      OP_LO_BIT: begin
        seq_scl = 1'b0;
        seq_sda_low = ~seq_shift[7];
      end
      OP_LO_REL: begin
        seq_scl = 1'b0;
        seq_sda_low = 1'b0;
      end
      OP_ACK_SLOT: seq_sda_low = seq_ack_choice;
      default: begin
      end
    endcase
  endfunction

  function automatic bus_beat_t step_bus_model(input req_t r, input logic [7:0] d,
                                               input logic a, input logic s);
    bus_beat_t res;
    logic [15:0] hp;
    logic is_cmd;
    op_t op;
    res = '0;
    hp = (seq_half_period == 16'd0) ? 16'd1 : seq_half_period;
    is_cmd = (r != REQ_TICK) && (r != REQ_UNUSED);
    if (seq_busy) begin
      res.rej = is_cmd;
      seq_div = seq_div + 16'd1;
      if (seq_div >= hp) begin
        seq_div = '0;
        case (phase_action(seq_cmd, seq_phase))
          OP_HI_SHIFT: seq_shift = {seq_shift[6:0], 1'b0};
          OP_HI_READ:  seq_shift = {seq_shift[6:0], s};
          OP_HI_ACK:   seq_last_ack = ~s;
          default: begin
          end
        endcase
        seq_phase++;
        op = phase_action(seq_cmd, seq_phase);
        if (op == OP_END) begin
          if (seq_cmd == REQ_READ) seq_read_byte = seq_shift;
          seq_busy = 1'b0;
          seq_phase = 0;
          res.done = 1'b1;
        end else begin
          apply_phase(op);
        end
      end
    end else if (is_cmd) begin
      seq_cmd = r;
      seq_phase = 0;
      seq_div = '0;
      seq_shift = (r == REQ_READ) ? 8'h00 : d;
      seq_ack_choice = a;
      seq_busy = 1'b1;
      apply_phase(phase_action(r, 0));
    end
    res.scl = seq_scl;
    res.sda_low = seq_sda_low;
    res.busy = seq_busy;
    res.rd = seq_read_byte;
    res.ack = seq_last_ack;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(input req_t r, input logic [7:0] d, input logic a, input logic s);
    int unsigned gap;
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    data_byte <= d;
    send_ack <= a;
    sda_in <= s;
    do @(posedge clk); while (in_stall);
    expected_bus_beats.push_back(step_bus_model(r, d, a, s));
  endtask

  // sda_mode 0 or 1 holds SDA at that level; anything else randomizes it.
  task automatic finish_command(input int sda_mode);
    logic s;
    while (seq_busy) begin
      s = (sda_mode == 0 || sda_mode == 1) ? sda_mode[0] : 1'($urandom_range(0, 1));
      send_beat(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s);
    end
  endtask

  task automatic settle();
    finish_command(2);
    in_valid <= 1'b0;
    while (expected_bus_beats.size() > 0) @(posedge clk);
  endtask

  task automatic load_half_period(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    seq_half_period = v;
  endtask

  task automatic write_half_period(input logic [15:0] v);
    settle();
    load_half_period(v);
  endtask

  task automatic test_default_period();
    send_beat(REQ_START, 8'h00, 1'b0, 1'b1);
    finish_command(2);
  endtask

  task automatic test_every_command();
    write_half_period(16'd1);
    send_beat(REQ_UNUSED, 8'hFF, 1'b1, 1'b0);
    send_beat(REQ_START, 8'h3C, 1'b0, 1'b1);
    finish_command(1);
    send_beat(REQ_START_ADR, 8'hFF, 1'b1, 1'b0);
    finish_command(0);
    send_beat(REQ_START_ADR, 8'h00, 1'b0, 1'b1);
    finish_command(1);
    send_beat(REQ_WRITE, 8'h00, 1'b0, 1'b0);
    finish_command(0);
    send_beat(REQ_WRITE, 8'hFF, 1'b1, 1'b1);
    finish_command(1);
    send_beat(REQ_WRITE_NA, 8'hA5, 1'b0, 1'b0);
    finish_command(0);
    send_beat(REQ_WRITE_NA, 8'h5A, 1'b1, 1'b1);
    finish_command(1);
    send_beat(REQ_READ, 8'hFF, 1'b1, 1'b0);
    finish_command(0);
    send_beat(REQ_READ, 8'h00, 1'b0, 1'b1);
    finish_command(1);
    send_beat(REQ_STOP, 8'h81, 1'b1, 1'b1);
    finish_command(2);
  endtask

  task automatic test_zero_period();
    write_half_period(16'd0);
    send_beat(REQ_WRITE, 8'h96, 1'b0, 1'b1);
    finish_command(2);
    send_beat(REQ_READ, 8'h00, 1'b1, 1'b1);
    finish_command(2);
  endtask

  task automatic test_busy_requests();
    write_half_period(16'd3);
    send_beat(REQ_START, 8'h12, 1'b0, 1'b1);
    for (int k = 0; k < 8; k++) begin
      send_beat(req_t'(k), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
    finish_command(2);
    // A request on every busy tick also lands on the completing tick.
    send_beat(REQ_STOP, 8'h00, 1'b0, 1'b1);
    while (seq_busy) begin
      send_beat(REQ_READ, 8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
    end
    send_beat(REQ_WRITE, 8'hC3, 1'b0, 1'b0);
    finish_command(2);
  endtask

  // The divider runs for a while at the widest period, then the period is cut short.
  task automatic test_long_period();
    write_half_period(16'hFFFF);
    send_beat(REQ_START, 8'h00, 1'b0, 1'b1);
    repeat (40) begin
      send_beat(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;
    while (expected_bus_beats.size() > 0) @(posedge clk);
    load_half_period(16'd1);
    finish_command(2);
  endtask

  task automatic test_back_pressure();
    write_half_period(16'd1);
    hold_request = 400;
    send_beat(REQ_WRITE, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
    repeat (60) begin
      send_beat(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    finish_command(2);
  endtask

  task automatic test_random_traffic();
    logic [15:0] periods[5];
    int unsigned roll;
    req_t r;
    periods = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1};
    periods[4] = 16'($urandom_range(4, 9));
    for (int ph = 0; ph < 5; ph++) begin
      write_half_period(periods[ph]);
      idle_enable = (ph != 0);
      for (int n = 0; n < 70; n++) begin
        roll = $urandom_range(0, 99);
        if (!seq_busy) begin
          r = (roll < 85) ? req_t'($urandom_range(1, 6)) : ((roll < 93) ? REQ_TICK : REQ_UNUSED);
        end else begin
          r = (roll < 85) ? REQ_TICK : ((roll < 93) ? req_t'($urandom_range(1, 6)) : REQ_UNUSED);
        end
        send_beat(r, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_enable) begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    bus_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_bus_beats.size() == 0) begin
        $error("result beat arrived with no expectation pending");
        error_count++;
      end else begin
        want = expected_bus_beats.pop_front();
        check_field("scl_level", 8'(want.scl), 8'(scl_level));
        check_field("sda_drive_low", 8'(want.sda_low), 8'(sda_drive_low));
        check_field("busy_res", 8'(want.busy), 8'(busy_res));
        check_field("done_res", 8'(want.done), 8'(done_res));
        check_field("read_byte", want.rd, read_byte);
        check_field("ack_received", 8'(want.ack), 8'(ack_received));
        check_field("rejected", 8'(want.rej), 8'(rejected));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    error_count = 0;
    idle_enable = 1'b0;
    hold_request = 0;
    seq_half_period = HalfPeriodReset;
    seq_phase = 0;
    seq_cmd = REQ_TICK;
    seq_shift = '0;
    seq_div = '0;
    seq_ack_choice = 1'b0;
    seq_last_ack = 1'b0;
    seq_scl = 1'b1;
    seq_sda_low = 1'b0;
    seq_busy = 1'b0;
    seq_read_byte = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    req_type <= REQ_TICK;
    data_byte <= '0;
    send_ack <= 1'b0;
    sda_in <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_period();
    test_every_command();
    test_zero_period();
    test_busy_requests();
    test_long_period();
    test_back_pressure();
    test_random_traffic();

    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_bus_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> i2c_master_bit_sequencer_unit.f
sv/i2cmbs_pkg.sv
sv/i2c_master_bit_sequencer_unit.sv
tb/tb_i2c_master_bit_sequencer_unit.sv
